### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define LLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LLP_ASSERT(lbl, prop, msg)
`define LLP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### src/llp_pkg.sv
package llp_pkg;

  localparam int VALUE_W      = 32;
  localparam int RUN_LENGTH_W = 11;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RUN_LENGTH_W-1:0]   run_length_t;

  typedef struct packed {
    run_length_t run_length;
    logic        overflow;
    logic        last_res;
  } result_t;

endpackage

### src/llp_if.sv
interface llp_in_if;
  import llp_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface llp_out_if;
  import llp_pkg::*;

  logic        valid;
  logic        ready;
  run_length_t run_length;
  logic        overflow;
  logic        last_res;

  modport source (output valid, output run_length, output overflow, output last_res,
                  input ready);
  modport sink   (input valid, input run_length, input overflow, input last_res,
                  output ready);
endinterface

### src/llp_tail_mem.sv
module llp_tail_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  llp_pkg::value_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output llp_pkg::value_t rd_data
);
  import llp_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/llp_search.sv
`include "assert_macros.svh"

module llp_search #(
  parameter int MAX_LEN = 1024,
  parameter int LW      = 11,
  parameter int AW      = 10
) (
  input  logic             clk,
  input  logic             rst,
  llp_in_if.sink           items,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  llp_pkg::value_t  rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output llp_pkg::value_t  wr_data,
  output logic             res_valid,
  output llp_pkg::result_t res,
  input  logic             res_ready
);
  import llp_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    EMIT
  } state_t;

  localparam logic [LW-1:0] MAX_LEN_L = LW'(MAX_LEN);

  state_t        state;
  value_t        key;
  logic          last_q;
  logic [LW-1:0] lo;
  logic [LW-1:0] hi;
  logic [LW-1:0] probe;
  logic          pending;
  logic [LW-1:0] len;
  logic          ovf;

  logic          less;
  logic [LW-1:0] lo_next;
  logic [LW-1:0] hi_next;
  logic [LW-1:0] mid_next;
  logic          found;

  // fold in the probe that just came back from memory
  always_comb begin
    less     = pending && (rd_data < key);
    lo_next  = lo;
    hi_next  = hi;
    if (pending) begin
      if (less) begin
        lo_next = probe + LW'(1);
      end else begin
        hi_next = probe;
      end
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
    found    = (lo_next == hi_next);
  end

  assign items.ready = (state == IDLE);

  assign rd_en   = (state == SEARCH) && !found;
  assign rd_addr = mid_next[AW-1:0];

  // search lands at len when the value extends the run; skip that when full
  assign wr_en   = (state == SEARCH) && found && ((lo_next < len) || (len < MAX_LEN_L));
  assign wr_addr = lo_next[AW-1:0];
  assign wr_data = key;

  assign res_valid      = (state == EMIT);
  assign res.run_length = RUN_LENGTH_W'(len);
  assign res.overflow   = ovf;
  assign res.last_res   = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      pending <= 1'b0;
      len     <= '0;
      ovf     <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (items.valid) begin
            key     <= items.value;
            last_q  <= items.last;
            lo      <= '0;
            hi      <= len;
            pending <= 1'b0;
            state   <= SEARCH;
          end
        end
        SEARCH: begin
          if (found) begin
            pending <= 1'b0;
            if (lo_next == len) begin
              if (len < MAX_LEN_L) begin
                len <= len + LW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
            state <= EMIT;
          end else begin
            lo      <= lo_next;
            hi      <= hi_next;
            probe   <= mid_next;
            pending <= 1'b1;
          end
        end
        EMIT: begin
          if (res_ready) begin
            if (last_q) begin
              len <= '0;
              ovf <= 1'b0;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `LLP_ASSERT(no_rd_wr_overlap, !(rd_en && wr_en), "read and write in the same cycle")
  `LLP_ASSERT(len_in_range, len <= MAX_LEN_L, "length beyond table capacity")
  `LLP_ASSERT(ovf_only_when_full, ovf |-> (len == MAX_LEN_L), "overflow without full table")
  `LLP_ASSERT(bounds_ordered, (state == SEARCH) |-> (lo <= hi && hi <= len), "bad search bounds")
  `LLP_ASSERT(last_clears, (state == EMIT && res_ready && last_q) |=> (len == '0 && !ovf), "sequence not closed")

endmodule

### src/lis_length_patience_unit.sv
// channel  | dir | payload                          | handshake
// items    | in  | value (s32), last                | valid/ready
// results  | out | run_length (11), overflow, last_res | valid/ready
//
// an item transfers in IDLE, the search then makes its tail memory probes in
// SEARCH, at most clog2(len + 1) of them (up to 11 with 1024 entries), and EMIT
// hands its result to the output register, from which it is offered on results;
// one probe a cycle through the single read port of the tail memory
// one item in flight; the next is taken once the current result has moved
// into the output register, even while that register waits on results.ready
// rst is synchronous; the tail memory needs no clearing; the length, overflow flag and control state reset

module lis_length_patience_unit #(
  parameter int MAX_LEN = 1024
) (
  input  logic      clk,
  input  logic      rst,
  llp_in_if.sink    items,
  llp_out_if.source results
);
  import llp_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  value_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  value_t        wr_data;
  logic          res_valid;
  result_t       res;
  logic          res_ready;

  logic          out_valid;
  result_t       out_data;

  llp_tail_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  llp_search #(
    .MAX_LEN (MAX_LEN),
    .LW      (LW),
    .AW      (AW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register frees as its transfer completes
  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_data <= res;
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.run_length = out_data.run_length;
  assign results.overflow   = out_data.overflow;
  assign results.last_res   = out_data.last_res;

endmodule
